@@ rtl/dmp_pkg.sv @@
// shared types and constants of the diameter message parser
`timescale 1ns / 1ps
package dmp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 24;
  localparam int unsigned IdW      = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 192;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [LenW-1:0]  HdrBytes    = LenW'(20);
  localparam logic [LenW-1:0]  AvpMinLeft  = LenW'(12);
  localparam logic [LenW-1:0]  AvpHdrPlain = LenW'(8);
  localparam logic [LenW-1:0]  AvpHdrVend  = LenW'(12);
  localparam logic [LenW-1:0]  AvpHdrSkip  = LenW'(8);
  localparam logic [LenW-1:0]  VendorSkip  = LenW'(4);
  localparam logic [ByteW-1:0] Version     = ByteW'(1);
  localparam int unsigned      VendorBit   = 7;

  localparam logic [PhaseW-1:0] PH_IDLE    = 3'd0;
  localparam logic [PhaseW-1:0] PH_HEADER  = 3'd1;
  localparam logic [PhaseW-1:0] PH_AVPHDR  = 3'd2;
  localparam logic [PhaseW-1:0] PH_VENDOR  = 3'd3;
  localparam logic [PhaseW-1:0] PH_DATA    = 3'd4;
  localparam logic [PhaseW-1:0] PH_DISCARD = 3'd5;

  localparam logic [KindW-1:0] KIND_HEADER = 2'd0;
  localparam logic [KindW-1:0] KIND_AVP    = 2'd1;
  localparam logic [KindW-1:0] KIND_DONE   = 2'd2;
  localparam logic [KindW-1:0] KIND_ERROR  = 2'd3;

  localparam logic [StatusW-1:0] ST_OK         = 3'd0;
  localparam logic [StatusW-1:0] ST_SHORT_BUF  = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_VER    = 3'd2;
  localparam logic [StatusW-1:0] ST_LEN_OVER   = 3'd3;
  localparam logic [StatusW-1:0] ST_AVP_CUT    = 3'd4;
  localparam logic [StatusW-1:0] ST_AVP_SMALL  = 3'd5;
  localparam logic [StatusW-1:0] ST_DATA_OVER  = 3'd6;

  // header field end positions
  localparam logic [LenW-1:0] POS_VERSION = LenW'(0);
  localparam logic [LenW-1:0] POS_MSGLEN  = LenW'(3);
  localparam logic [LenW-1:0] POS_FLAGS   = LenW'(4);
  localparam logic [LenW-1:0] POS_CMD     = LenW'(7);
  localparam logic [LenW-1:0] POS_APPID   = LenW'(11);
  localparam logic [LenW-1:0] POS_HOP     = LenW'(15);
  localparam logic [LenW-1:0] POS_E2E     = LenW'(19);

  // avp header byte indexes
  localparam logic [3:0] AVP_K_CODE  = 4'd3;
  localparam logic [3:0] AVP_K_FLAGS = 4'd4;
  localparam logic [3:0] AVP_K_LEN   = 4'd7;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     code;
    logic [ByteW-1:0]   flags;
    logic [IdW-1:0]     ident_a;
    logic [IdW-1:0]     ident_b;
    logic [IdW-1:0]     ident_c;
    logic [LenW-1:0]    offset;
    logic [LenW-1:0]    length;
    logic               eom;
  } rec_t;

endpackage

@@ rtl/diameter_message_parser_unit.sv @@
// diameter message parser: byte stream in, header, avp and closing records out
`timescale 1ns / 1ps
// Takes one buffer byte per cycle and returns header, AVP descriptor and
// done/error records. A byte sits in an input register and is parsed when
// the 4-entry result queue has room for two records, so the block sustains
// one byte per clock while the result side keeps taking records.
// A byte that raises two records (header plus a closing record, descriptor
// plus a closing record, or a record plus the buffer-end error) fills two
// queue slots; the result port drains one record per cycle, so a run of such
// bytes is paced by that port.
module diameter_message_parser_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [dmp_pkg::InDataW-1:0]   s_axis_tdata,  // in_byte, buffer_length
  input  logic                          s_axis_tuser,  // first_byte
  input  logic                          s_axis_tlast,  // last_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, code, flag_bits, ident_a, ident_b, ident_c, data_offset,
  // length_out, zero fill
  output logic [dmp_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [dmp_pkg::KindW-1:0]     m_axis_tuser,  // record_kind
  output logic                          m_axis_tlast   // end_of_message
);
  import dmp_pkg::*;

  // input register
  logic             in_vld;
  logic [ByteW-1:0] in_b;
  logic             in_first;
  logic             in_last;
  logic [LenW-1:0]  in_blen;

  // parser state
  logic [PhaseW-1:0] phase;
  logic [LenW-1:0]   byte_position;
  logic [LenW-1:0]   message_length;
  logic [LenW-1:0]   buffer_total;
  logic [IdW-1:0]    field_shift;
  logic [IdW-1:0]    saved_code;
  logic [ByteW-1:0]  saved_flags;
  logic [IdW-1:0]    saved_ident_a;
  logic [IdW-1:0]    saved_ident_b;
  logic [LenW-1:0]   avp_length;
  logic [LenW-1:0]   skip_remaining;

  logic [PhaseW-1:0] phase_next;
  logic [LenW-1:0]   byte_position_next;
  logic [LenW-1:0]   message_length_next;
  logic [LenW-1:0]   buffer_total_next;
  logic [IdW-1:0]    field_shift_next;
  logic [IdW-1:0]    saved_code_next;
  logic [ByteW-1:0]  saved_flags_next;
  logic [IdW-1:0]    saved_ident_a_next;
  logic [IdW-1:0]    saved_ident_b_next;
  logic [LenW-1:0]   avp_length_next;
  logic [LenW-1:0]   skip_remaining_next;

  // result queue
  rec_t             queue [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] q_count;

  logic       proc;
  logic       pop;
  logic [1:0] n_rec;
  rec_t       slot0;
  rec_t       slot1;

  logic            emit_main;
  rec_t            main_rec;
  logic            emit_close;
  logic [KindW-1:0]   close_kind;
  logic [StatusW-1:0] close_status;
  logic            emit_err;

  assign proc          = in_vld && (q_count <= QCntW'(QDepth - 2));
  assign s_axis_tready = !in_vld || proc;
  assign pop           = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_b     <= s_axis_tdata[ByteW-1:0];
      in_blen  <= s_axis_tdata[ByteW +: LenW];
      in_first <= s_axis_tuser;
      in_last  <= s_axis_tlast;
    end
  end

  always_comb begin
    logic [LenW-1:0] pos;
    logic [3:0]      k;
    logic [LenW-1:0] hdr;
    logic            hdr_done;
    logic            start_req;
    logic [LenW-1:0] dlen;
    logic [LenW-1:0] left;
    logic [LenW:0]   padded;

    phase_next          = phase;
    byte_position_next  = byte_position;
    message_length_next = message_length;
    buffer_total_next   = buffer_total;
    field_shift_next    = field_shift;
    saved_code_next     = saved_code;
    saved_flags_next    = saved_flags;
    saved_ident_a_next  = saved_ident_a;
    saved_ident_b_next  = saved_ident_b;
    avp_length_next     = avp_length;
    skip_remaining_next = skip_remaining;

    emit_main    = 1'b0;
    main_rec     = '0;
    emit_close   = 1'b0;
    close_kind   = KIND_ERROR;
    close_status = ST_OK;
    emit_err     = 1'b0;
    hdr_done     = 1'b0;
    start_req    = 1'b0;
    hdr          = AvpHdrPlain;
    pos          = '0;
    k            = '0;
    dlen         = '0;
    left         = '0;
    padded       = '0;

    if (in_first) begin
      phase_next          = PH_HEADER;
      byte_position_next  = '0;
      message_length_next = '0;
      buffer_total_next   = in_blen;
      field_shift_next    = '0;
      saved_code_next     = '0;
      saved_flags_next    = '0;
      saved_ident_a_next  = '0;
      saved_ident_b_next  = '0;
      avp_length_next     = '0;
      skip_remaining_next = '0;
    end

    if (phase_next != PH_IDLE && phase_next != PH_DISCARD) begin
      pos                = byte_position_next;
      byte_position_next = pos + LenW'(1);
      case (phase_next)
        PH_HEADER: begin
          field_shift_next = {field_shift_next[IdW-ByteW-1:0], in_b};
          if (pos == POS_VERSION) begin
            if (buffer_total_next < HdrBytes) begin
              emit_close   = 1'b1;
              close_status = ST_SHORT_BUF;
            end else if (in_b != Version) begin
              emit_close   = 1'b1;
              close_status = ST_BAD_VER;
            end
          end else if (pos == POS_MSGLEN) begin
            message_length_next = field_shift_next[LenW-1:0];
            if (message_length_next > buffer_total_next) begin
              emit_close   = 1'b1;
              close_status = ST_LEN_OVER;
            end
          end else if (pos == POS_FLAGS) begin
            saved_flags_next = in_b;
          end else if (pos == POS_CMD) begin
            saved_code_next = {{(IdW-LenW){1'b0}}, field_shift_next[LenW-1:0]};
          end else if (pos == POS_APPID) begin
            saved_ident_a_next = field_shift_next;
          end else if (pos == POS_HOP) begin
            saved_ident_b_next = field_shift_next;
          end else if (pos == POS_E2E) begin
            emit_main        = 1'b1;
            main_rec.kind    = KIND_HEADER;
            main_rec.status  = ST_OK;
            main_rec.code    = saved_code_next;
            main_rec.flags   = saved_flags_next;
            main_rec.ident_a = saved_ident_a_next;
            main_rec.ident_b = saved_ident_b_next;
            main_rec.ident_c = field_shift_next;
            main_rec.length  = message_length_next;
            start_req        = 1'b1;
          end
        end
        PH_AVPHDR: begin
          k                   = 4'd8 - skip_remaining_next[3:0];
          skip_remaining_next = skip_remaining_next - LenW'(1);
          field_shift_next    = {field_shift_next[IdW-ByteW-1:0], in_b};
          if (k == AVP_K_CODE) begin
            saved_code_next = field_shift_next;
          end else if (k == AVP_K_FLAGS) begin
            saved_flags_next = in_b;
          end else if (k == AVP_K_LEN) begin
            avp_length_next = field_shift_next[LenW-1:0];
            hdr = saved_flags_next[VendorBit] ? AvpHdrVend : AvpHdrPlain;
            if (avp_length_next < hdr) begin
              emit_close   = 1'b1;
              close_status = ST_AVP_SMALL;
            end else if (saved_flags_next[VendorBit]) begin
              phase_next          = PH_VENDOR;
              skip_remaining_next = VendorSkip;
            end else begin
              saved_ident_a_next = '0;
              hdr_done           = 1'b1;
            end
          end
        end
        PH_VENDOR: begin
          field_shift_next    = {field_shift_next[IdW-ByteW-1:0], in_b};
          skip_remaining_next = skip_remaining_next - LenW'(1);
          hdr                 = AvpHdrVend;
          if (skip_remaining_next == '0) begin
            saved_ident_a_next = field_shift_next;
            hdr_done           = 1'b1;
          end
        end
        PH_DATA: begin
          skip_remaining_next = skip_remaining_next - LenW'(1);
          if (skip_remaining_next == '0) begin
            start_req = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // avp header complete
    if (hdr_done) begin
      dlen = avp_length_next - hdr;
      left = message_length_next - byte_position_next;
      if (dlen > left) begin
        emit_close   = 1'b1;
        close_status = ST_DATA_OVER;
      end else begin
        emit_main        = 1'b1;
        main_rec.kind    = KIND_AVP;
        main_rec.status  = ST_OK;
        main_rec.code    = saved_code_next;
        main_rec.flags   = saved_flags_next;
        main_rec.ident_a = saved_ident_a_next;
        main_rec.offset  = byte_position_next;
        main_rec.length  = dlen;
        padded = {1'b0, dlen} +
                 ((dlen[1:0] != 2'd0) ? (LenW+1)'(3'd4 - {1'b0, dlen[1:0]})
                                      : (LenW+1)'(0));
        skip_remaining_next = (padded < {1'b0, left}) ? padded[LenW-1:0] : left;
        if (skip_remaining_next == '0) begin
          start_req = 1'b1;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end

    // next avp or end of message
    if (start_req) begin
      if (byte_position_next >= message_length_next) begin
        emit_close   = 1'b1;
        close_kind   = KIND_DONE;
        close_status = ST_OK;
      end else if (message_length_next - byte_position_next < AvpMinLeft) begin
        emit_close   = 1'b1;
        close_status = ST_AVP_CUT;
      end else begin
        phase_next          = PH_AVPHDR;
        skip_remaining_next = AvpHdrSkip;
      end
    end

    if (emit_close) begin
      phase_next = PH_DISCARD;
    end

    if (in_last) begin
      if (phase_next != PH_IDLE && phase_next != PH_DISCARD) begin
        emit_err = 1'b1;
      end
      phase_next = PH_IDLE;
    end
  end

  // order the records of one byte into queue slots
  always_comb begin
    rec_t close_rec;
    rec_t err_rec;

    close_rec        = '0;
    close_rec.kind   = close_kind;
    close_rec.status = close_status;
    close_rec.eom    = 1'b1;
    err_rec          = '0;
    err_rec.kind     = KIND_ERROR;
    err_rec.status   = ST_SHORT_BUF;
    err_rec.eom      = 1'b1;

    n_rec = 2'(emit_main) + 2'(emit_close) + 2'(emit_err);
    if (emit_main) begin
      slot0 = main_rec;
    end else if (emit_close) begin
      slot0 = close_rec;
    end else begin
      slot0 = err_rec;
    end
    if (emit_main && emit_close) begin
      slot1 = close_rec;
    end else begin
      slot1 = err_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      byte_position  <= '0;
      message_length <= '0;
      buffer_total   <= '0;
      field_shift    <= '0;
      saved_code     <= '0;
      saved_flags    <= '0;
      saved_ident_a  <= '0;
      saved_ident_b  <= '0;
      avp_length     <= '0;
      skip_remaining <= '0;
    end else if (proc) begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      message_length <= message_length_next;
      buffer_total   <= buffer_total_next;
      field_shift    <= field_shift_next;
      saved_code     <= saved_code_next;
      saved_flags    <= saved_flags_next;
      saved_ident_a  <= saved_ident_a_next;
      saved_ident_b  <= saved_ident_b_next;
      avp_length     <= avp_length_next;
      skip_remaining <= skip_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (proc) begin
        wr_ptr <= wr_ptr + QPtrW'(n_rec);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      q_count <= q_count + (proc ? QCntW'(n_rec) : QCntW'(0)) - QCntW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (proc && n_rec != 2'd0) begin
      queue[wr_ptr] <= slot0;
    end
    if (proc && n_rec == 2'd2) begin
      queue[wr_ptr + QPtrW'(1)] <= slot1;
    end
  end

  assign m_axis_tvalid = (q_count != '0);
  assign m_axis_tuser  = queue[rd_ptr].kind;
  assign m_axis_tlast  = queue[rd_ptr].eom;
  assign m_axis_tdata  = {5'b0,
                          queue[rd_ptr].length,
                          queue[rd_ptr].offset,
                          queue[rd_ptr].ident_c,
                          queue[rd_ptr].ident_b,
                          queue[rd_ptr].ident_a,
                          queue[rd_ptr].flags,
                          queue[rd_ptr].code,
                          queue[rd_ptr].status};

endmodule

@@ test/tb_diameter_message_parser_unit.sv @@
// testbench for the diameter message parser: byte streams against a record predictor
`timescale 1ns / 1ps
module tb_diameter_message_parser_unit;
  import dmp_pkg::*;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // in_byte, buffer_length
  logic                s_axis_tuser;   // first_byte
  logic                s_axis_tlast;   // last_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // status, code, flag_bits, ident_a, ident_b, ident_c,
                                       // data_offset, length_out, zero fill
  logic [KindW-1:0]    m_axis_tuser;   // record_kind
  logic                m_axis_tlast;   // end_of_message

  diameter_message_parser_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("diameter_message_parser_unit verification failed");
    $finish;
  end

  // parser state mirrored for prediction
  logic [PhaseW-1:0] parse_phase;
  logic [LenW-1:0]   parse_pos;
  logic [LenW-1:0]   parse_msg_len;
  logic [LenW-1:0]   parse_buf_total;
  logic [LenW-1:0]   parse_avp_len;
  logic [LenW-1:0]   parse_skip;
  logic [IdW-1:0]    parse_shift;
  logic [IdW-1:0]    parse_code;
  logic [IdW-1:0]    parse_id_a;
  logic [IdW-1:0]    parse_id_b;
  logic [ByteW-1:0]  parse_flags;
  int                step_records;
  int                parsed_bytes;
  int                mismatches;
  rec_t              expected_records[$];

  // message under construction
  logic [7:0] frame_bytes[$];
  int         avp_starts[$];

  bit gaps_on;
  int tx_burst_left;
  int rx_left;
  int rx_period;
  int rx_duty;
  int rx_phase;

  function automatic void clear_parser();
    parse_phase     = PH_IDLE;
    parse_pos       = '0;
    parse_msg_len   = '0;
    parse_buf_total = '0;
    parse_avp_len   = '0;
    parse_skip      = '0;
    parse_shift     = '0;
    parse_code      = '0;
    parse_id_a      = '0;
    parse_id_b      = '0;
    parse_flags     = '0;
  endfunction

  function automatic void emit_record(input logic [KindW-1:0] kind,
                                     input logic [StatusW-1:0] status,
                                     input logic [IdW-1:0] code, input logic [ByteW-1:0] flags,
                                     input logic [IdW-1:0] id_a, input logic [IdW-1:0] id_b,
                                     input logic [IdW-1:0] id_c, input logic [LenW-1:0] offset,
                                     input logic [LenW-1:0] length, input logic eom);
    rec_t r;
    if (step_records >= 2) return;
    r.kind    = kind;
    r.status  = status;
    r.code    = code;
    r.flags   = flags;
    r.ident_a = id_a;
    r.ident_b = id_b;
    r.ident_c = id_c;
    r.offset  = offset;
    r.length  = length;
    r.eom     = eom;
    expected_records.push_back(r);
    step_records++;
  endfunction

  function automatic void close_message(input logic [KindW-1:0] kind,
                                       input logic [StatusW-1:0] status);
    emit_record(kind, status, '0, '0, '0, '0, '0, '0, '0, 1'b1);
    parse_phase = PH_DISCARD;
  endfunction

  function automatic void begin_avp();
    if (parse_pos >= parse_msg_len) begin
      close_message(KIND_DONE, ST_OK);
    end else if (parse_msg_len - parse_pos < AvpMinLeft) begin
      close_message(KIND_ERROR, ST_AVP_CUT);
    end else begin
      parse_phase = PH_AVPHDR;
      parse_skip  = AvpHdrSkip;
    end
  endfunction

  function automatic void end_avp_header(input logic [LenW-1:0] hdr_len);
    logic [LenW-1:0] data_len;
    logic [LenW-1:0] room;
    logic [LenW+1:0] padded;
    logic [1:0]      pad;
    data_len = parse_avp_len - hdr_len;
    room     = parse_msg_len - parse_pos;
    if (data_len > room) begin
      close_message(KIND_ERROR, ST_DATA_OVER);
      return;
    end
    emit_record(KIND_AVP, ST_OK, parse_code, parse_flags, parse_id_a, '0, '0,
                parse_pos, data_len, 1'b0);
    pad        = 2'd0 - data_len[1:0];
    padded     = {2'b00, data_len} + {{LenW{1'b0}}, pad};
    parse_skip = (padded < room) ? padded[LenW-1:0] : room;
    if (parse_skip == 0) begin
      begin_avp();
    end else begin
      parse_phase = PH_DATA;
    end
  endfunction

  function automatic void header_byte(input logic [LenW-1:0] pos, input logic [7:0] b);
    parse_shift = {parse_shift[23:0], b};
    case (pos)
      POS_VERSION: begin
        if (parse_buf_total < HdrBytes) begin
          close_message(KIND_ERROR, ST_SHORT_BUF);
        end else if (b != Version) begin
          close_message(KIND_ERROR, ST_BAD_VER);
        end
      end
      POS_MSGLEN: begin
        parse_msg_len = parse_shift[LenW-1:0];
        if (parse_msg_len > parse_buf_total) close_message(KIND_ERROR, ST_LEN_OVER);
      end
      POS_FLAGS: parse_flags = b;
      POS_CMD:   parse_code  = {8'd0, parse_shift[23:0]};
      POS_APPID: parse_id_a  = parse_shift;
      POS_HOP:   parse_id_b  = parse_shift;
      POS_E2E: begin
        emit_record(KIND_HEADER, ST_OK, parse_code, parse_flags, parse_id_a, parse_id_b,
                    parse_shift, '0, parse_msg_len, 1'b0);
        begin_avp();
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic first, input logic last,
                                     input logic [LenW-1:0] blen);
    logic [LenW-1:0] pos;
    logic [3:0]      k;
    step_records = 0;
    parsed_bytes++;
    if (first) begin
      clear_parser();
      parse_buf_total = blen;
      parse_phase     = PH_HEADER;
    end
    if (parse_phase != PH_IDLE && parse_phase != PH_DISCARD) begin
      pos       = parse_pos;
      parse_pos = pos + LenW'(1);
      case (parse_phase)
        PH_HEADER: header_byte(pos, b);
        PH_AVPHDR: begin
          k = 4'(AvpHdrSkip - parse_skip);
          parse_skip--;
          parse_shift = {parse_shift[23:0], b};
          if (k == AVP_K_CODE) begin
            parse_code = parse_shift;
          end else if (k == AVP_K_FLAGS) begin
            parse_flags = b;
          end else if (k == AVP_K_LEN) begin
            parse_avp_len = parse_shift[LenW-1:0];
            if (parse_avp_len < (parse_flags[VendorBit] ? AvpHdrVend : AvpHdrPlain)) begin
              close_message(KIND_ERROR, ST_AVP_SMALL);
            end else if (parse_flags[VendorBit]) begin
              parse_phase = PH_VENDOR;
              parse_skip  = VendorSkip;
            end else begin
              parse_id_a = '0;
              end_avp_header(AvpHdrPlain);
            end
          end
        end
        PH_VENDOR: begin
          parse_shift = {parse_shift[23:0], b};
          parse_skip--;
          if (parse_skip == 0) begin
            parse_id_a = parse_shift;
            end_avp_header(AvpHdrVend);
          end
        end
        PH_DATA: begin
          parse_skip--;
          if (parse_skip == 0) begin_avp();
        end
        default: parse_phase = PH_IDLE;
      endcase
    end
    if (last) begin
      if (parse_phase != PH_IDLE && parse_phase != PH_DISCARD) begin
        emit_record(KIND_ERROR, ST_SHORT_BUF, '0, '0, '0, '0, '0, '0, '0, 1'b1);
      end
      parse_phase = PH_IDLE;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      parse_byte(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast, s_axis_tdata[31:8]);
    end
  end

  function automatic string rec_text(input rec_t r);
    return $sformatf("kind=%0d status=%0d code=%h flags=%h a=%h b=%h c=%h off=%0d len=%0d eom=%0b",
                     r.kind, r.status, r.code, r.flags, r.ident_a, r.ident_b, r.ident_c,
                     r.offset, r.length, r.eom);
  endfunction

  always @(posedge clk) begin : check_records
    rec_t got;
    rec_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind    = m_axis_tuser;
      got.status  = m_axis_tdata[2:0];
      got.code    = m_axis_tdata[34:3];
      got.flags   = m_axis_tdata[42:35];
      got.ident_a = m_axis_tdata[74:43];
      got.ident_b = m_axis_tdata[106:75];
      got.ident_c = m_axis_tdata[138:107];
      got.offset  = m_axis_tdata[162:139];
      got.length  = m_axis_tdata[186:163];
      got.eom     = m_axis_tlast;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("record with none expected: %s", rec_text(got));
      end else begin
        want = expected_records.pop_front();
        if (got.kind !== want.kind || got.status !== want.status || got.code !== want.code ||
            got.flags !== want.flags || got.ident_a !== want.ident_a ||
            got.ident_b !== want.ident_b || got.ident_c !== want.ident_c ||
            got.offset !== want.offset || got.length !== want.length ||
            got.eom !== want.eom) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("record mismatch at %0t", $realtime);
            $display("  expected %s", rec_text(want));
            $display("  actual   %s", rec_text(got));
          end
        end
      end
    end
  end

  // receiver stalls: random duty pattern, redrawn whenever its run ends
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_left   = $urandom_range(16, 160);
      rx_period = $urandom_range(1, 10);
      rx_duty   = ($urandom_range(0, 3) == 0) ? rx_period : $urandom_range(1, rx_period);
      rx_phase  = 0;
    end
    rx_left--;
    m_axis_tready <= (rx_phase < rx_duty);
    rx_phase = (rx_phase + 1 == rx_period) ? 0 : rx_phase + 1;
  end

  task automatic send_byte(input logic [7:0] b, input bit first, input bit last,
                           input logic [LenW-1:0] blen);
    if (tx_burst_left == 0) begin
      if (gaps_on) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      tx_burst_left = $urandom_range(1, 24);
    end
    tx_burst_left--;
    s_axis_tdata  <= {blen, b};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic void put_field(input logic [31:0] value, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) frame_bytes.push_back(8'(value >> (8 * i)));
  endfunction

  function automatic logic [LenW-1:0] frame_len();
    return LenW'(frame_bytes.size());
  endfunction

  function automatic void start_frame(input logic [7:0] version, input logic [7:0] flags,
                                      input logic [23:0] cmd, input logic [31:0] app,
                                      input logic [31:0] hop, input logic [31:0] e2e);
    frame_bytes.delete();
    avp_starts.delete();
    put_field(version, 1);
    put_field(0, 3);
    put_field(flags, 1);
    put_field(cmd, 3);
    put_field(app, 4);
    put_field(hop, 4);
    put_field(e2e, 4);
  endfunction

  function automatic void set_msg_length(input logic [LenW-1:0] len);
    frame_bytes[1] = len[23:16];
    frame_bytes[2] = len[15:8];
    frame_bytes[3] = len[7:0];
  endfunction

  function automatic void set_avp_length(input int idx, input logic [LenW-1:0] len);
    int p;
    p = avp_starts[idx];
    frame_bytes[p + 5] = len[23:16];
    frame_bytes[p + 6] = len[15:8];
    frame_bytes[p + 7] = len[7:0];
  endfunction

  function automatic void add_avp(input logic [31:0] code, input logic [7:0] flags,
                                  input logic [31:0] vendor, input int data_len);
    int hdr;
    hdr = flags[VendorBit] ? 12 : 8;
    avp_starts.push_back(frame_bytes.size());
    put_field(code, 4);
    put_field(flags, 1);
    put_field(hdr + data_len, 3);
    if (flags[VendorBit]) put_field(vendor, 4);
    for (int i = 0; i < data_len; i++) frame_bytes.push_back(8'($urandom));
    for (int i = 0; i < ((4 - (data_len % 4)) % 4); i++) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_random_avp(input int max_len);
    logic [7:0] flags;
    flags            = 8'($urandom);
    flags[VendorBit] = ($urandom_range(0, 2) == 0);
    add_avp($urandom, flags, $urandom, $urandom_range(0, max_len));
  endfunction

  task automatic send_frame(input logic [LenW-1:0] blen, input int count, input bit with_last);
    for (int i = 0; i < count; i++) begin
      send_byte(frame_bytes[i], i == 0, with_last && (i == count - 1),
                (i == 0) ? blen : LenW'($urandom));
    end
  endtask

  task automatic send_exact();
    send_frame(frame_len(), frame_bytes.size(), 1'b1);
  endtask

  task automatic send_stray(input int n);
    repeat (n) send_byte(8'($urandom), 1'b0, $urandom_range(0, 1) != 0, LenW'($urandom));
  endtask

  task automatic test_header_checks();
    // all-ones header fields, then all zeros with message length 0
    start_frame(Version, 8'hFF, 24'hFFFFFF, '1, '1, '1);
    set_msg_length(20);
    send_exact();
    start_frame(Version, 8'h00, 24'h0, '0, '0, '0);
    set_msg_length(0);
    send_exact();
    // buffer shorter than the header
    start_frame(Version, 8'h80, 24'h000101, 32'd1, 32'd2, 32'd3);
    set_msg_length(20);
    send_frame(19, 20, 1'b1);
    send_frame(0, 20, 1'b1);
    // bad version
    frame_bytes[0] = 8'h00;
    send_exact();
    frame_bytes[0] = 8'hFF;
    send_exact();
    // message length past the buffer
    frame_bytes[0] = Version;
    set_msg_length(21);
    send_exact();
    set_msg_length('1);
    send_frame(24'hFFFFFE, 20, 1'b1);
    // largest lengths, buffer runs out right after an avp
    add_avp(32'h0000_0108, 8'h40, '0, 6);
    set_msg_length('1);
    send_frame('1, frame_bytes.size(), 1'b1);
  endtask

  task automatic test_avp_forms();
    // plain and vendor avps with every padding amount
    start_frame(Version, 8'hC0, 24'd272, $urandom, $urandom, $urandom);
    add_avp(32'd0, 8'h00, '0, 0);
    add_avp('1, 8'h7F, '0, 1);
    add_avp(32'd263, 8'h40, '0, 2);
    add_avp(32'd1, 8'h20, '0, 3);
    add_avp(32'd443, 8'hFF, '1, 4);
    add_avp(32'd444, 8'h80, '0, 5);
    set_msg_length(frame_len());
    send_exact();
    // avp length below its header size
    start_frame(Version, 8'h00, 24'd257, $urandom, $urandom, $urandom);
    add_avp(32'd1, 8'h00, '0, 4);
    set_msg_length(frame_len());
    set_avp_length(0, 7);
    send_exact();
    set_avp_length(0, 0);
    send_exact();
    start_frame(Version, 8'h00, 24'd257, $urandom, $urandom, $urandom);
    add_avp(32'd1, 8'h80, 32'd10415, 4);
    set_msg_length(frame_len());
    set_avp_length(0, 11);
    send_exact();
    // data past the message end
    set_avp_length(0, '1);
    send_exact();
    // fewer than 12 bytes left at an avp start, plain and vendor flag
    start_frame(Version, 8'h80, 24'd280, $urandom, $urandom, $urandom);
    add_avp(32'd5, 8'h00, '0, 3);
    set_msg_length(31);
    send_exact();
    frame_bytes[24] = 8'h80;
    send_exact();
    // padding cut by the message length
    start_frame(Version, 8'h00, 24'd258, $urandom, $urandom, $urandom);
    add_avp(32'd9, 8'h00, '0, 5);
    set_msg_length(frame_len() - LenW'(3));
    send_exact();
    // trailing bytes after done
    start_frame(Version, 8'h40, 24'd271, $urandom, $urandom, $urandom);
    add_avp(32'd263, 8'h40, '0, 8);
    set_msg_length(frame_len());
    repeat (7) frame_bytes.push_back(8'($urandom));
    send_exact();
  endtask

  task automatic test_buffer_edges();
    start_frame(Version, 8'h80, 24'd316, $urandom, $urandom, $urandom);
    add_avp(32'd7, 8'h00, '0, 4);
    add_avp(32'd8, 8'h80, 32'd3, 10);
    set_msg_length(frame_len());
    // buffer ends inside the header, at its end, at an avp header, inside data
    send_frame(frame_len(), 10, 1'b1);
    send_frame(frame_len(), 20, 1'b1);
    send_frame(frame_len(), 28, 1'b1);
    send_frame(frame_len(), frame_bytes.size() - 2, 1'b1);
    // new buffer while a message is open
    send_frame(frame_len(), 33, 1'b0);
    send_exact();
    // stray bytes while idle
    send_stray(6);
    // one-byte buffers
    send_frame(20, 1, 1'b1);
    send_frame(5, 1, 1'b1);
  endtask

  task automatic test_random_traffic();
    int              count;
    int              pick;
    logic [LenW-1:0] blen;
    bit              with_last;
    while (parsed_bytes < 1700) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        // garbage buffer
        frame_bytes.delete();
        count = $urandom_range(1, 30);
        repeat (count) frame_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1)) frame_bytes[0] = Version;
        send_frame(LenW'($urandom), count, $urandom_range(0, 1) != 0);
      end else begin
        start_frame(Version, 8'($urandom), 24'($urandom), $urandom, $urandom, $urandom);
        repeat ($urandom_range(0, 5)) add_random_avp(($urandom_range(0, 4) == 0) ? 40 : 12);
        set_msg_length(frame_len());
        blen      = frame_len();
        count     = frame_bytes.size();
        with_last = 1'b1;
        pick      = $urandom_range(0, 15);
        case (pick)
          0: frame_bytes[0] = 8'($urandom);
          1: set_msg_length(frame_len() - LenW'($urandom_range(0, 8)));
          2: begin
            set_msg_length(frame_len() + LenW'($urandom_range(1, 8)));
            blen = frame_len() + LenW'($urandom_range(0, 8));
          end
          3: if (avp_starts.size() != 0) begin
            set_avp_length($urandom_range(0, avp_starts.size() - 1),
                           LenW'($urandom_range(0, 13)));
          end
          4: if (avp_starts.size() != 0) begin
            set_avp_length($urandom_range(0, avp_starts.size() - 1), LenW'($urandom));
          end
          5: count = $urandom_range(1, frame_bytes.size());
          6: begin
            count     = $urandom_range(1, frame_bytes.size());
            with_last = 1'b0;
          end
          7: begin
            repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
            blen  = frame_len();
            count = frame_bytes.size();
          end
          8: blen = ($urandom_range(0, 1)) ? LenW'($urandom_range(0, 19)) : LenW'($urandom);
          default: ;
        endcase
        send_frame(blen, count, with_last);
      end
      if ($urandom_range(0, 7) == 0) send_stray($urandom_range(1, 4));
    end
  endtask

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    gaps_on       = 1'b1;
    tx_burst_left = 0;
    parsed_bytes  = 0;
    mismatches    = 0;
    clear_parser();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_header_checks();
    test_avp_forms();
    test_buffer_edges();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    while (expected_records.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("diameter_message_parser_unit verification clean");
    end else begin
      $display("diameter_message_parser_unit verification failed");
    end
    $finish;
  end

endmodule
